### rtl/atot_pkg.sv
// ----------------------------------------------------------------------------
// atot_pkg
// Shared widths, limits and divider request/response types for the
// average time over threshold block.
// ----------------------------------------------------------------------------
package atot_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 16;
    localparam int CTR_W    = 13;
    localparam int SUM_W    = 13;
    localparam int RUNS_W   = 12;
    localparam int AVG_W    = 13;

    // Saturation limits
    localparam logic [CTR_W-1:0]  CTR_MAX  = {CTR_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [RUNS_W-1:0] RUNS_MAX = {RUNS_W{1'b1}};

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request to the divider
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [RUNS_W-1:0] divisor;
    } div_req_t;

    // Response from the divider
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/atot_div.sv
// ----------------------------------------------------------------------------
// atot_div
// Restoring divider: one shared subtractor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atot_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  atot_pkg::div_req_t  req,
    output atot_pkg::div_rsp_t  rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [atot_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [atot_pkg::RUNS_W-1:0]     rem_reg, rem_next;
    logic [atot_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [atot_pkg::RUNS_W-1:0]     dvsr_reg, dvsr_next;

    logic [atot_pkg::SUM_W-1:0]      trial;
    logic [atot_pkg::SUM_W:0]        diff;
    logic                            fits;

    // Shared trial subtraction
    assign trial = {rem_reg, quo_reg[atot_pkg::SUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvsr_reg};
    assign fits  = ~diff[atot_pkg::SUM_W];

    // Step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = atot_pkg::DIV_CNT_W'(atot_pkg::DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[atot_pkg::RUNS_W-1:0] : trial[atot_pkg::RUNS_W-1:0];
            quo_next = {quo_reg[atot_pkg::SUM_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    // A finished division always follows a busy period
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a preceding busy period");

    // Step count holds while idle unless a new division starts
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> (cnt_reg == $past(cnt_reg)) || $past(req.start))
        else $error("divider step count moved while idle");

    // A start always arms the counter for a full division
    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg &&
            (cnt_reg == atot_pkg::DIV_CNT_W'(atot_pkg::DIV_STEPS - 1)))
        else $error("divider start did not arm a full division");
`endif

endmodule

### rtl/average_time_over_threshold_core.sv
// ----------------------------------------------------------------------------
// average_time_over_threshold_core
// Mean length of over-threshold runs per segment of signed samples.
// ----------------------------------------------------------------------------
// One request is taken at a time. An ordinary sample is registered on
// acceptance and then updates the run state before the next one can be
// accepted. A sample flagged last with completed runs adds a division in
// a shared restoring divider (one quotient bit per cycle), then a step to
// take the quotient and one to load the output register; with no completed
// run the result is 0 and no division is made. The result sits in an output
// register, so the next sample may be taken while it waits on m_ready; a new
// result that finds that register still occupied waits for m_ready and holds
// off further samples meanwhile. The threshold is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, as the block
// itself does not enforce this.
module average_time_over_threshold_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic signed [atot_pkg::SAMPLE_W-1:0] cfg_wr_data,
    // sample requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [atot_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_is_first,
    input  logic                                s_is_last,
    // result requests
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [atot_pkg::AVG_W-1:0]          m_average_duration
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic signed [atot_pkg::SAMPLE_W-1:0] thr_reg;
    logic signed [atot_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                first_reg, last_reg;

    logic                                above_reg, above_next;
    logic [atot_pkg::CTR_W-1:0]          ctr_reg, ctr_next;
    logic [atot_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [atot_pkg::RUNS_W-1:0]         runs_reg, runs_next;

    logic [atot_pkg::AVG_W-1:0]          result_reg, result_next;
    logic                                m_valid_reg, m_valid_next;
    logic [atot_pkg::AVG_W-1:0]          m_avg_reg, m_avg_next;

    logic                                over;
    logic [atot_pkg::SUM_W:0]            sum_wide;
    logic [atot_pkg::CTR_W-1:0]          ctr_mid;
    logic                                accept;

    atot_pkg::div_req_t                  div_req;
    atot_pkg::div_rsp_t                  div_rsp;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign over    = (sample_reg >= thr_reg);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, ctr_reg};

    // Run state update for one sample
    always_comb begin
        above_next = above_reg;
        ctr_mid    = ctr_reg;
        sum_next   = sum_reg;
        runs_next  = runs_reg;
        ctr_next   = ctr_reg;
        if (first_reg) begin
            above_next = over;
            ctr_next   = atot_pkg::CTR_W'(1);
            sum_next   = '0;
            runs_next  = '0;
        end else begin
            if (above_reg && !over) begin
                sum_next   = sum_wide[atot_pkg::SUM_W] ? atot_pkg::SUM_MAX
                                                       : sum_wide[atot_pkg::SUM_W-1:0];
                runs_next  = (runs_reg == atot_pkg::RUNS_MAX) ? runs_reg
                                                              : runs_reg + 1'b1;
                ctr_mid    = '0;
                above_next = 1'b0;
            end else if (!above_reg && over) begin
                ctr_mid    = '0;
                above_next = 1'b1;
            end
            ctr_next = (ctr_mid == atot_pkg::CTR_MAX) ? ctr_mid : ctr_mid + 1'b1;
        end
    end

    // Divider request
    assign div_req.start    = (state_reg == ST_UPDATE) && last_reg && (runs_next != '0);
    assign div_req.dividend = sum_next;
    assign div_req.divisor  = runs_next;

    atot_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer and output register
    always_comb begin
        state_next   = state_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_avg_next   = m_avg_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (runs_next == '0) begin
                    result_next = '0;
                    state_next  = ST_RESULT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    result_next = div_rsp.quotient;
                    state_next  = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            above_reg   <= 1'b0;
            ctr_reg     <= '0;
            sum_reg     <= '0;
            runs_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (state_reg == ST_UPDATE) begin
                above_reg <= above_next;
                ctr_reg   <= ctr_next;
                sum_reg   <= sum_next;
                runs_reg  <= runs_next;
            end
        end
        if (accept) begin
            sample_reg <= s_sample;
            first_reg  <= s_is_first;
            last_reg   <= s_is_last;
        end
        result_reg <= result_next;
        m_avg_reg  <= m_avg_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_average_duration = m_avg_reg;

`ifndef SYNTHESIS
    // An accepted sample is always applied in the next cycle
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_UPDATE)
        else $error("accepted sample not applied");

    // Run state holds while a division is in flight
    a_sum_stable_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> $stable(sum_reg) && $stable(runs_reg))
        else $error("run state changed during division");

    // The mean never exceeds the summed duration
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_rsp.done) |-> div_rsp.quotient <= sum_reg)
        else $error("quotient above dividend");

    // A result is only loaded when the output register is free or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_avg_reg))
        else $error("pending result overwritten");
`endif

endmodule
